/* src/brs_pkg.sv */
// Shared types and constants for the bilinear RGB sampler.
// Depends on nothing; every other file of the block but brs_ram imports it.
`default_nettype none

package brs_pkg;

  // Image geometry and sample position format.
  localparam int IMG_COLS  = 256;
  localparam int IMG_ROWS  = 256;
  localparam int FRAC_BITS = 8;

  // Fixed field widths of the channel beats.
  localparam int POS_W    = 16;
  localparam int COORD_W  = 8;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;

  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  localparam int COL_W = $clog2(IMG_COLS);
  localparam int ROW_W = $clog2(IMG_ROWS);

  // The store is split into four banks by column and row parity.
  localparam int BANK_COLS  = (IMG_COLS + 1) / 2;
  localparam int BANK_ROWS  = (IMG_ROWS + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Blend arithmetic widths.
  localparam int WGT_W = FRAC_BITS + 1;
  localparam int TOP_W = CHAN_W + FRAC_BITS;
  localparam int ACC_W = CHAN_W + 2 * FRAC_BITS + 1;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef logic [FRAC_BITS-1:0]             frac_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]  pixel_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pixel_t           px;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] x0;
    logic [COL_W-1:0] x1;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
  } rd_req_t;

  typedef struct packed {
    logic  valid;
    frac_t fx;
    frac_t fy;
  } smp_ctl_t;

  typedef struct packed {
    pixel_t p00;
    pixel_t p10;
    pixel_t p01;
    pixel_t p11;
  } quad_t;

endpackage

`default_nettype wire

/* src/brs_if.sv */
// Valid/ready channel interfaces for the sampler's input and result beats.
// Depends on brs_pkg for the field widths.
`default_nettype none

interface brs_in_if
  import brs_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] pixel_col;
  logic [COORD_W-1:0] pixel_row;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;
  logic [POS_W-1:0]   x_pos;
  logic [POS_W-1:0]   y_pos;

  modport source (
    output valid, req_type, pixel_col, pixel_row, red_in, green_in, blue_in, x_pos, y_pos,
    input  ready
  );
  modport sink (
    input  valid, req_type, pixel_col, pixel_row, red_in, green_in, blue_in, x_pos, y_pos,
    output ready
  );
endinterface

interface brs_out_if
  import brs_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;

  modport source (
    output valid, red_out, green_out, blue_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out,
    output ready
  );
endinterface

`default_nettype wire

/* src/bilinear_rgb_sampler.sv */
// Bilinear RGB888 sampler top level: address decode, read stage, and the
// pipeline glue. Depends on brs_pkg, brs_if, brs_pixel_store and brs_blend.
//
// The block takes one beat per clock unless the result side stalls, writes and
// queries mixed freely. A write stores one pixel and returns nothing. A query
// returns one blended pixel. The bank read is issued when the query is accepted,
// the horizontal blend is then registered in the blend stage, and the vertical
// blend lands in the output register after it. The throughput of one item per
// cycle comes from the pixel store being split into four banks by column and
// row parity, each with its own write port and read port, so all four neighbors
// are read at once while a write lands in a single bank. Stalls on the result
// side back up through the pipeline registers; the input stays ready as long as
// some stage has room. The store is not cleared at reset: a query must only
// touch pixels that were written since, and there is no start-up sweep.
`default_nettype none

module bilinear_rgb_sampler
  import brs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  brs_in_if.sink    in_bus,
  brs_out_if.source out_bus
);

  logic             accept;
  logic             is_query;
  logic             s1_take;
  logic             s1_load;
  logic             s1_v_r;
  frac_t            fx_r, fy_r;
  frac_t            fx, fy;
  logic [POS_W-1:0] xi, yi;
  logic [COL_W-1:0] x0, x1;
  logic [ROW_W-1:0] y0, y1;
  wr_req_t          wr;
  rd_req_t          rd;
  smp_ctl_t         s1;
  quad_t            quad;

  assign s1_load      = !s1_v_r || s1_take;
  assign in_bus.ready = s1_load;
  assign accept       = in_bus.valid && s1_load;
  assign is_query     = in_bus.req_type == REQ_QUERY;

  // Integer parts saturate to the last column and row; the ceil does too.
  always_comb begin
    fx = in_bus.x_pos[FRAC_BITS-1:0];
    fy = in_bus.y_pos[FRAC_BITS-1:0];
    xi = in_bus.x_pos >> FRAC_BITS;
    yi = in_bus.y_pos >> FRAC_BITS;
    x0 = (int'(xi) >= IMG_COLS) ? COL_W'(IMG_COLS - 1) : COL_W'(xi);
    y0 = (int'(yi) >= IMG_ROWS) ? ROW_W'(IMG_ROWS - 1) : ROW_W'(yi);
    x1 = ((fx != '0) && (x0 != COL_W'(IMG_COLS - 1))) ? x0 + COL_W'(1) : x0;
    y1 = ((fy != '0) && (y0 != ROW_W'(IMG_ROWS - 1))) ? y0 + ROW_W'(1) : y0;
  end

  always_comb begin
    wr.en  = accept && !is_query &&
             (int'(in_bus.pixel_col) < IMG_COLS) && (int'(in_bus.pixel_row) < IMG_ROWS);
    wr.col = COL_W'(in_bus.pixel_col);
    wr.row = ROW_W'(in_bus.pixel_row);
    wr.px[CH_RED]   = in_bus.red_in;
    wr.px[CH_GREEN] = in_bus.green_in;
    wr.px[CH_BLUE]  = in_bus.blue_in;

    // The bank read data only moves when the read stage moves.
    rd.en = s1_load;
    rd.x0 = x0;
    rd.x1 = x1;
    rd.y0 = y0;
    rd.y1 = y1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= accept && is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      fx_r <= fx;
      fy_r <= fy;
    end
  end

  always_comb begin
    s1.valid = s1_v_r;
    s1.fx    = fx_r;
    s1.fy    = fy_r;
  end

  brs_pixel_store u_store (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .quad (quad)
  );

  brs_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1      (s1),
    .quad    (quad),
    .s1_take (s1_take),
    .out_bus (out_bus)
  );

`ifndef SYNTHESIS
  a_write_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.req_type == REQ_WRITE) |=> !s1_v_r)
    else $error("write beat entered the blend pipeline");

  a_query_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_bus.req_type == REQ_QUERY) |=> s1_v_r)
    else $error("accepted query did not reach the read stage");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_bus.ready)
    else $error("input stalled while the read stage was empty");
`endif

endmodule

`default_nettype wire

/* src/brs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`default_nettype none

module brs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/brs_pixel_store.sv */
// Pixel store: four parity banks that deliver all four neighbors in one read.
// Depends on brs_pkg and brs_ram.
`default_nettype none

module brs_pixel_store
  import brs_pkg::*;
(
  input  wire logic    clk,
  input  wire wr_req_t wr,
  input  wire rd_req_t rd,
  output quad_t        quad
);

  pixel_t bank_q [4];
  logic   x0p_r, x1p_r, y0p_r, y1p_r;

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [COL_W-1:0] c,
                                                    input logic [ROW_W-1:0] r);
    return BANK_AW'(int'(r >> 1) * BANK_COLS + int'(c >> 1));
  endfunction

  // Bank index is {row parity, column parity}.
  function automatic pixel_t pick(input logic [1:0] sel, input pixel_t q0, input pixel_t q1,
                                  input pixel_t q2, input pixel_t q3);
    pixel_t res;
    case (sel)
      2'd0:    res = q0;
      2'd1:    res = q1;
      2'd2:    res = q2;
      2'd3:    res = q3;
      default: res = q0;
    endcase
    return res;
  endfunction

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = (b % 2) == 1;
    localparam logic RP = (b / 2) == 1;

    logic [COL_W-1:0]   rcol;
    logic [ROW_W-1:0]   rrow;
    logic               we;
    logic [BANK_AW-1:0] waddr;
    logic [BANK_AW-1:0] raddr;

    // Floor and ceil differ by at most one, so each bank sees exactly one of them.
    always_comb begin
      rcol  = (rd.x0[0] == CP) ? rd.x0 : rd.x1;
      rrow  = (rd.y0[0] == RP) ? rd.y0 : rd.y1;
      raddr = bank_addr(rcol, rrow);
      waddr = bank_addr(wr.col, wr.row);
      we    = wr.en && (wr.col[0] == CP) && (wr.row[0] == RP);
    end

    brs_ram #(
      .WIDTH ($bits(pixel_t)),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wr.px),
      .re    (rd.en),
      .raddr (raddr),
      .rdata (bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      x0p_r <= rd.x0[0];
      x1p_r <= rd.x1[0];
      y0p_r <= rd.y0[0];
      y1p_r <= rd.y1[0];
    end
  end

  always_comb begin
    quad.p00 = pick({y0p_r, x0p_r}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
    quad.p10 = pick({y0p_r, x1p_r}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
    quad.p01 = pick({y1p_r, x0p_r}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
    quad.p11 = pick({y1p_r, x1p_r}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
  end

endmodule

`default_nettype wire

/* src/brs_blend.sv */
// Two-stage blend pipeline: horizontal blend, then vertical blend with rounding
// into the output register. Depends on brs_pkg and brs_if.
`default_nettype none

module brs_blend
  import brs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire smp_ctl_t s1,
  input  wire quad_t    quad,
  output logic          s1_take,
  brs_out_if.source     out_bus
);

  localparam logic [WGT_W-1:0] WGT_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);

  logic                        s2_v_r;
  frac_t                       fy_r;
  logic [NUM_CHAN-1:0][TOP_W-1:0] top_r, top_nxt;
  logic [NUM_CHAN-1:0][TOP_W-1:0] bot_r, bot_nxt;
  logic                        out_v_r;
  pixel_t                      res_r, res_nxt;
  logic                        out_load;
  logic [WGT_W-1:0]            wx0, wx1, wy0, wy1;
  logic [ACC_W-1:0]            acc [NUM_CHAN];

  assign out_load = !out_v_r || out_bus.ready;
  assign s1_take  = !s2_v_r || out_load;

  // A zero fraction gives the ceil neighbour zero weight, so the floor passes exactly.
  always_comb begin
    wx1 = {1'b0, s1.fx};
    wx0 = WGT_ONE - wx1;
    for (int c = 0; c < NUM_CHAN; c++) begin
      top_nxt[c] = TOP_W'(quad.p00[c]) * TOP_W'(wx0) + TOP_W'(quad.p10[c]) * TOP_W'(wx1);
      bot_nxt[c] = TOP_W'(quad.p01[c]) * TOP_W'(wx0) + TOP_W'(quad.p11[c]) * TOP_W'(wx1);
    end
  end

  always_comb begin
    wy1 = {1'b0, fy_r};
    wy0 = WGT_ONE - wy1;
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc[c]     = ACC_W'(top_r[c]) * ACC_W'(wy0) + ACC_W'(bot_r[c]) * ACC_W'(wy1) + ACC_HALF;
      res_nxt[c] = acc[c][2*FRAC_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s2_v_r <= s1.valid;
      end
      if (out_load) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      fy_r  <= s1.fy;
      top_r <= top_nxt;
      bot_r <= bot_nxt;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid     = out_v_r;
  assign out_bus.red_out   = res_r[CH_RED];
  assign out_bus.green_out = res_r[CH_GREEN];
  assign out_bus.blue_out  = res_r[CH_BLUE];

`ifndef SYNTHESIS
  a_out_from_s2 : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !$past(out_v_r)) |-> $past(s2_v_r))
    else $error("result beat appeared without a blended sample behind it");
`endif

endmodule

`default_nettype wire
